@@ design/assert_macros.svh @@
// assertion macros used by the top-level design file
// no dependencies; the synthesis build defines SYNTH and gets empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// expr holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk_s, rst_s, expr) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (expr)) \
        else $error("assertion failed");

// when trig holds, expr holds in the next cycle
`define ASSERT_NEXT(lbl, clk_s, rst_s, trig, expr) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (trig) |=> (expr)) \
        else $error("assertion failed");

// when trig holds, expr holds in the same cycle
`define ASSERT_IMPLY(lbl, clk_s, rst_s, trig, expr) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (trig) |-> (expr)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk_s, rst_s, expr)
`define ASSERT_NEXT(lbl, clk_s, rst_s, trig, expr)
`define ASSERT_IMPLY(lbl, clk_s, rst_s, trig, expr)

`endif

`endif

@@ design/kbdi_pkg.sv @@
// package for the k best distance insertion block
// constants, codes, controller states and command/status structs; no dependencies
package kbdi_pkg;

    localparam int K_MAX_DEF     = 16;
    localparam int DIST_BITS_DEF = 32;

    localparam int KUSED_W = 5;
    localparam int EPS_W   = 16;
    localparam int TIE_W   = 16;
    localparam int IDX_W   = 4;
    localparam int OUTD_W  = 32;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [TIE_W-1:0]   TIE_MAX       = '1;
    localparam logic [KUSED_W-1:0] KUSED_RESET   = 5'd1;
    localparam logic [EPS_W-1:0]   EPSILON_RESET = 16'd1;

    // action codes
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_ADD   = 2'd1;
    localparam logic [1:0] ACT_DUMP  = 2'd2;

    // register indexes (address bit 2)
    localparam logic REG_K_USED  = 1'b0;
    localparam logic REG_EPSILON = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD,
        ST_ADD_OUT,
        ST_DUMP
    } kbdi_state_t;

    typedef struct packed {
        logic capture;
        logic clear;
        logic compare;
        logic update;
        logic cnt_clear;
        logic cnt_worst;
        logic cnt_inc;
        logic out_load;
        logic out_last;
        logic out_is_add;
    } kbdi_cmd_t;

    typedef struct packed {
        logic out_free;
        logic cnt_is_last;
    } kbdi_stat_t;

endpackage

@@ design/k_best_distance_insert.sv @@
// top level of the k best distance insertion block
// depends on kbdi_pkg, kbdi_regs, kbdi_ctrl, kbdi_dp and assert_macros.svh
//
//  channel   signals                                        direction
//  input     in_valid, in_ready, action, distance            in
//  output    out_valid, out_ready, out_distance, tie_count,  out
//            slot_index, slot_valid, last
//  config    psel, penable, pwrite, paddr, pwdata, prdata,   in/out
//            pready
//
// an add steps through capture, parallel slot compare, insert/shift, result load (waits for a free output)
// a dump gives one result per cycle while the output is free, one per slot up to k_used (1..K_MAX)
// clear finishes at the accepting edge; action 3 is dropped
// one item in work at a time; a waiting result holds the item behind it
// rst_n clears all slots and loads k_used = 1, epsilon = 1
`include "assert_macros.svh"

module k_best_distance_insert
    import kbdi_pkg::*;
#(
    parameter int K_MAX     = K_MAX_DEF,
    parameter int DIST_BITS = DIST_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           action,
    input  logic [DIST_BITS-1:0] distance,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [OUTD_W-1:0]    out_distance,
    output logic [TIE_W-1:0]     tie_count,
    output logic [IDX_W-1:0]     slot_index,
    output logic                 slot_valid,
    output logic                 last,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready
);

    localparam int KW = $clog2(K_MAX + 1);

    logic [KW-1:0]    k_eff;
    logic [EPS_W-1:0] epsilon;
    logic             cfg_clear;
    kbdi_cmd_t        cmd;
    kbdi_stat_t       stat;
    logic             busy;
    logic [K_MAX-1:0] filled_mask;

    kbdi_regs #(
        .K_MAX (K_MAX)
    ) u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .k_eff     (k_eff),
        .epsilon   (epsilon),
        .cfg_clear (cfg_clear)
    );

    kbdi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    kbdi_dp #(
        .K_MAX     (K_MAX),
        .DIST_BITS (DIST_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .distance     (distance),
        .k_eff        (k_eff),
        .epsilon      (epsilon),
        .cfg_clear    (cfg_clear),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .out_distance (out_distance),
        .tie_count    (tie_count),
        .slot_index   (slot_index),
        .slot_valid   (slot_valid),
        .last         (last),
        .filled_mask  (filled_mask)
    );

    // filled slots always form an unbroken run from slot 0
    `ASSERT_ALWAYS(a_filled_run, clk, rst_n, ((filled_mask + K_MAX'(1)) & filled_mask) == '0)
    // an accepted add or dump keeps the input closed for the next cycle
    `ASSERT_NEXT(a_busy_after_add, clk, rst_n, in_valid && in_ready && (action == ACT_ADD || action == ACT_DUMP), busy && !in_ready)
    // an empty slot reports no distance and no ties
    `ASSERT_IMPLY(a_empty_zero, clk, rst_n, out_valid && !slot_valid, out_distance == '0 && tie_count == '0)

endmodule

@@ design/kbdi_regs.sv @@
// configuration registers k_used and epsilon behind the APB-style port
// depends on kbdi_pkg; gives the effective slot count and a slot clear pulse
module kbdi_regs
    import kbdi_pkg::*;
#(
    parameter int K_MAX = K_MAX_DEF,
    localparam int KW = $clog2(K_MAX + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic [KW-1:0]     k_eff,
    output logic [EPS_W-1:0]  epsilon,
    output logic              cfg_clear
);

    logic [KUSED_W-1:0] k_used_reg;
    logic [EPS_W-1:0]   epsilon_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_used_reg  <= KUSED_RESET;
            epsilon_reg <= EPSILON_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_K_USED:  k_used_reg  <= pwdata[KUSED_W-1:0];
                REG_EPSILON: epsilon_reg <= pwdata[EPS_W-1:0];
                default:     k_used_reg  <= k_used_reg;
            endcase
        end
    end

    // a new k_used starts a new search
    assign cfg_clear = wr_en && (paddr[2] == REG_K_USED);

    always_comb
    begin
        case (paddr[2])
            REG_K_USED:  prdata = DATA_W'(k_used_reg);
            REG_EPSILON: prdata = DATA_W'(epsilon_reg);
            default:     prdata = '0;
        endcase
    end

    always_comb
    begin
        if (k_used_reg == '0)
            k_eff = KW'(1);
        else if (int'(k_used_reg) > K_MAX)
            k_eff = KW'(K_MAX);
        else
            k_eff = KW'(k_used_reg);
    end

    assign epsilon = epsilon_reg;

endmodule

@@ design/kbdi_ctrl.sv @@
// controller for the k best distance insertion block
// depends on kbdi_pkg; drives datapath commands from the input item and status
module kbdi_ctrl
    import kbdi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] action,
    input  kbdi_stat_t stat,
    output kbdi_cmd_t  cmd,
    output logic       busy
);

    kbdi_state_t state_reg;
    kbdi_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (action)
                        ACT_CLEAR: cmd.clear = 1'b1;
                        ACT_ADD:
                        begin
                            cmd.capture = 1'b1;
                            state_next  = ST_CMP;
                        end
                        ACT_DUMP:
                        begin
                            cmd.cnt_clear = 1'b1;
                            state_next    = ST_DUMP;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CMP:
            begin
                cmd.compare = 1'b1;
                state_next  = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.update    = 1'b1;
                cmd.cnt_worst = 1'b1;
                state_next    = ST_ADD_OUT;
            end
            ST_ADD_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_last   = 1'b1;
                    cmd.out_is_add = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_DUMP:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = stat.cnt_is_last;
                    cmd.cnt_inc  = 1'b1;
                    if (stat.cnt_is_last)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

@@ design/kbdi_dp.sv @@
// datapath: slot row with per-slot compare, insert/shift update and result register
// depends on kbdi_pkg; commanded by kbdi_ctrl
module kbdi_dp
    import kbdi_pkg::*;
#(
    parameter int K_MAX     = K_MAX_DEF,
    parameter int DIST_BITS = DIST_BITS_DEF,
    localparam int KW = $clog2(K_MAX + 1),
    localparam int IW = (K_MAX > 1) ? $clog2(K_MAX) : 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  kbdi_cmd_t            cmd,
    output kbdi_stat_t           stat,
    input  logic [DIST_BITS-1:0] distance,
    input  logic [KW-1:0]        k_eff,
    input  logic [EPS_W-1:0]     epsilon,
    input  logic                 cfg_clear,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [OUTD_W-1:0]    out_distance,
    output logic [TIE_W-1:0]     tie_count,
    output logic [IDX_W-1:0]     slot_index,
    output logic                 slot_valid,
    output logic                 last,
    output logic [K_MAX-1:0]     filled_mask
);

    localparam int CW = (DIST_BITS > EPS_W) ? DIST_BITS : EPS_W;

    logic [DIST_BITS-1:0] dist_reg [K_MAX];
    logic [TIE_W-1:0]     tie_reg  [K_MAX];
    logic [K_MAX-1:0]     filled_reg;
    logic [DIST_BITS-1:0] d_reg;

    logic [DIST_BITS-1:0] diff_c [K_MAX];
    logic [K_MAX-1:0]     ge_c;
    logic [K_MAX-1:0]     tie_c;
    logic [K_MAX-1:0]     in_range;
    logic [K_MAX-1:0]     hit_next;
    logic [K_MAX-1:0]     hit_reg;
    logic [K_MAX-1:0]     tie_hit_reg;
    logic [K_MAX-1:0]     prior_hit;
    logic [K_MAX-1:0]     first;
    logic                 first_tie;
    logic                 any_hit;

    logic [IW-1:0]        cnt_reg;
    logic [IW-1:0]        worst_idx;
    logic                 out_valid_reg;
    logic [OUTD_W-1:0]    out_dist_reg;
    logic [TIE_W-1:0]     out_tie_reg;
    logic [IDX_W-1:0]     out_idx_reg;
    logic                 out_slot_valid_reg;
    logic                 out_last_reg;

    // per-slot compare against the captured distance
    always_comb
    begin
        for (int i = 0; i < K_MAX; i++)
        begin
            ge_c[i]     = (d_reg >= dist_reg[i]);
            diff_c[i]   = ge_c[i] ? (d_reg - dist_reg[i]) : (dist_reg[i] - d_reg);
            tie_c[i]    = filled_reg[i] && (CW'(diff_c[i]) < CW'(epsilon));
            in_range[i] = (i < int'(k_eff));
            hit_next[i] = in_range[i] && (tie_c[i] || !filled_reg[i] || !ge_c[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            d_reg <= distance;
        if (cmd.compare)
        begin
            hit_reg     <= hit_next;
            tie_hit_reg <= tie_c;
        end
    end

    // first matching slot, nearest first
    always_comb
    begin
        for (int i = 0; i < K_MAX; i++)
        begin
            prior_hit[i] = |(hit_reg & ({K_MAX{1'b1}} >> (K_MAX - i)));
            first[i]     = hit_reg[i] && !prior_hit[i];
        end
    end

    assign first_tie = |(first & tie_hit_reg);
    assign any_hit   = |hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            filled_reg <= '0;
        else if (cfg_clear || cmd.clear)
            filled_reg <= '0;
        else if (cmd.update && any_hit && !first_tie)
        begin
            for (int i = 0; i < K_MAX; i++)
            begin
                if (first[i])
                    filled_reg[i] <= 1'b1;
                else if (i > 0 && prior_hit[i] && in_range[i])
                    filled_reg[i] <= filled_reg[(i > 0) ? i - 1 : 0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update && any_hit)
        begin
            for (int i = 0; i < K_MAX; i++)
            begin
                if (first_tie)
                begin
                    if (first[i] && tie_reg[i] != TIE_MAX)
                        tie_reg[i] <= tie_reg[i] + TIE_W'(1);
                end
                else if (first[i])
                begin
                    dist_reg[i] <= d_reg;
                    tie_reg[i]  <= TIE_W'(1);
                end
                else if (i > 0 && prior_hit[i] && in_range[i])
                begin
                    dist_reg[i] <= dist_reg[(i > 0) ? i - 1 : 0];
                    tie_reg[i]  <= tie_reg[(i > 0) ? i - 1 : 0];
                end
            end
        end
    end

    // slot read pointer: dump walk or worst slot
    assign worst_idx = IW'(k_eff - KW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.cnt_clear)
            cnt_reg <= '0;
        else if (cmd.cnt_worst)
            cnt_reg <= worst_idx;
        else if (cmd.cnt_inc)
            cnt_reg <= IW'(cnt_reg + IW'(1));
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_dist_reg       <= filled_reg[cnt_reg] ? OUTD_W'(dist_reg[cnt_reg]) : '0;
            out_tie_reg        <= (filled_reg[cnt_reg] && !cmd.out_is_add) ?
                                  tie_reg[cnt_reg] : '0;
            out_idx_reg        <= IDX_W'(cnt_reg);
            out_slot_valid_reg <= filled_reg[cnt_reg];
            out_last_reg       <= cmd.out_last;
        end
    end

    assign stat.out_free    = !out_valid_reg || out_ready;
    assign stat.cnt_is_last = (cnt_reg == worst_idx);

    assign out_valid    = out_valid_reg;
    assign out_distance = out_dist_reg;
    assign tie_count    = out_tie_reg;
    assign slot_index   = out_idx_reg;
    assign slot_valid   = out_slot_valid_reg;
    assign last         = out_last_reg;
    assign filled_mask  = filled_reg;

endmodule
